// ----- hdl/boundary_tag_next_fit_allocator_defines.svh -----
// Assertion macros shared by the allocator RTL.
`ifndef BOUNDARY_TAG_NEXT_FIT_ALLOCATOR_DEFINES_SVH
`define BOUNDARY_TAG_NEXT_FIT_ALLOCATOR_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define BTNF_CHECK(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define BTNF_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/btnf_pkg.sv -----
// Package: command and status codes and the result item type.
`default_nettype none
package btnf_pkg;

  typedef enum logic [1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_NOP   = 2'd3
  } command_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_HEAP = 2'd1,
    ST_ZERO    = 2'd2,
    ST_NO_INIT = 2'd3
  } status_t;

  typedef struct packed {
    logic [15:0] payload_offset;
    status_t     status;
  } out_item_t;

endpackage
`default_nettype wire

// ----- hdl/boundary_tag_next_fit_allocator.sv -----
// Top level: boundary-tag heap allocator with next-fit search over a tag memory.
//
// Usage: a command transfer on the in_ channel (init, allocate, free, or no-op)
// yields exactly one result transfer on the out_ channel: payload offset and
// status. One command is worked at a time; in_stall is high from the accepting
// edge until the edge at which its result is loaded into the output register.
// The tag memory read is registered. Init writes the prologue and epilogue and
// grows the break. Free of an offset rejected at decode touches no tag; else
// it checks header and footer, clears them and coalesces. Allocate on zero
// size or before init touches no tag; otherwise it walks block headers from
// the rover, grows the break when no block fits, and places the block. The
// walk over block headers sets the rate.
// Reset clears the break, the rover and the initialized flag; the tag memory
// is not cleared (tags are written by init before they are read).
// When the receiver stalls, the result sits in the output register and the
// next command is still taken; its result waits in the sequencer until the
// output register is free.
`default_nettype none
`include "boundary_tag_next_fit_allocator_defines.svh"
module boundary_tag_next_fit_allocator #(
  parameter int HEAP_BYTES  = 65536,
  parameter int CHUNK_BYTES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_command,
  input  wire logic [15:0] in_request_bytes,
  input  wire logic [15:0] in_block_offset,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_payload_offset,
  output logic [1:0]       out_status
);
  import btnf_pkg::*;

  // byte address width with headroom for wrapped differences and large requests
  localparam int AW    = ($clog2(HEAP_BYTES) + 2 > 18) ? $clog2(HEAP_BYTES) + 2 : 18;
  localparam int TW    = $clog2(HEAP_BYTES);
  localparam int LIMIT = HEAP_BYTES / 8 + 2;
  localparam int CW    = $clog2(LIMIT + 1);
  localparam logic [AW-1:0] HEAP_A  = AW'(HEAP_BYTES);
  localparam logic [AW-1:0] CHUNK_A = AW'(CHUNK_BYTES);

  typedef enum logic [5:0] {
    S_IDLE, S_I0, S_I1, S_I2, S_I3,
    S_G0, S_G1, S_G2, S_G3,
    S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6,
    S_MA1, S_MA2, S_MB1, S_MB2, S_MC1, S_MC2, S_MR,
    S_L1_RD, S_L1_CK, S_L2_RD, S_L2_CK,
    S_C0, S_C1, S_C2, S_C3, S_C4, S_C5, S_C6, S_C7,
    S_F0, S_F1, S_F2, S_F3, S_F4,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    RET_INIT, RET_ALLOC, RET_FREE
  } ret_t;

  state_t         state_r, state_nxt;
  ret_t           ret_r, ret_nxt;
  logic           init_r, init_nxt;
  logic [AW-1:0]  brk_r, brk_nxt;
  logic [AW-1:0]  rover_r, rover_nxt;
  logic [AW-1:0]  bp_r, bp_nxt;
  logic [AW-1:0]  asize_r, asize_nxt;
  logic [AW-1:0]  s_r, s_nxt;
  logic [AW-1:0]  prev_r, prev_nxt;
  logic [AW-1:0]  phsz_r, phsz_nxt;
  logic [AW-1:0]  next_r, next_nxt;
  logic [AW-1:0]  nsz_r, nsz_nxt;
  logic           pa_r, pa_nxt;
  logic [AW-1:0]  start_r, start_nxt;
  logic [AW-1:0]  p_r, p_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [AW-1:0]  gbytes_r, gbytes_nxt;
  logic [TW-1:0]  h_r, h_nxt;
  logic [AW-1:0]  res_r, res_nxt;
  status_t        st_r, st_nxt;

  logic           ram_re, ram_we;
  logic [AW-1:0]  ram_addr;
  logic [TW-1:0]  ram_wd, rd_data;
  logic [AW-1:0]  szd, gw, gsz, rq, asz, off, csz_diff;
  logic           ald, merge_done, out_ready, out_push;
  out_item_t      out_item;

  btnf_tag_ram #(
    .HEAP_BYTES(HEAP_BYTES),
    .ADDR_W    (AW),
    .TAG_W     (TW)
  ) u_ram (
    .clk  (clk),
    .rd_en(ram_re),
    .wr_en(ram_we),
    .addr (ram_addr),
    .wdata(ram_wd),
    .rdata(rd_data)
  );

  // decoded fields of the tag that came back from the last read
  assign szd = AW'({rd_data[TW-1:3], 3'b000});
  assign ald = rd_data[0];

  // grow size: bytes rounded down to words, then up to an even word count
  assign gw  = gbytes_r >> 2;
  assign gsz = AW'({gw + AW'(gw[0]), 2'b00});

  assign rq  = AW'(in_request_bytes);
  assign asz = (rq <= AW'(8)) ? AW'(16) : ((rq + AW'(15)) & ~AW'(7));
  assign off = AW'(in_block_offset);
  assign csz_diff = s_r - asize_r;

  assign in_stall = (state_r != S_IDLE);
  assign out_push = (state_r == S_DONE) && out_ready;
  assign out_item = '{payload_offset: res_r[15:0], status: st_r};

  always_comb begin
    state_nxt  = state_r;
    ret_nxt    = ret_r;
    init_nxt   = init_r;
    brk_nxt    = brk_r;
    rover_nxt  = rover_r;
    bp_nxt     = bp_r;
    asize_nxt  = asize_r;
    s_nxt      = s_r;
    prev_nxt   = prev_r;
    phsz_nxt   = phsz_r;
    next_nxt   = next_r;
    nsz_nxt    = nsz_r;
    pa_nxt     = pa_r;
    start_nxt  = start_r;
    p_nxt      = p_r;
    cnt_nxt    = cnt_r;
    gbytes_nxt = gbytes_r;
    h_nxt      = h_r;
    res_nxt    = res_r;
    st_nxt     = st_r;
    ram_re     = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = '0;
    ram_wd     = '0;
    merge_done = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_nxt   = '0;
          st_nxt    = ST_OK;
          state_nxt = S_DONE;
          case (command_t'(in_command))
            CMD_INIT: begin
              brk_nxt   = AW'(16);
              rover_nxt = AW'(8);
              init_nxt  = 1'b0;
              state_nxt = S_I0;
            end
            CMD_ALLOC: begin
              if (!init_r) begin
                st_nxt = ST_NO_INIT;
              end else if (in_request_bytes == '0) begin
                st_nxt = ST_ZERO;
              end else begin
                asize_nxt = asz;
                start_nxt = rover_r;
                p_nxt     = rover_r;
                cnt_nxt   = '0;
                state_nxt = S_L1_RD;
              end
            end
            CMD_FREE: begin
              if (!init_r) begin
                st_nxt = ST_NO_INIT;
              end else if (off[2:0] == 3'b000 && off >= AW'(16) && off < brk_r) begin
                bp_nxt    = off;
                state_nxt = S_F0;
              end
            end
            default: ;
          endcase
        end
      end

      // prologue and epilogue
      S_I0: begin
        ram_we = 1'b1; ram_addr = AW'(0); ram_wd = TW'(0); state_nxt = S_I1;
      end
      S_I1: begin
        ram_we = 1'b1; ram_addr = AW'(4); ram_wd = TW'(9); state_nxt = S_I2;
      end
      S_I2: begin
        ram_we = 1'b1; ram_addr = AW'(8); ram_wd = TW'(9); state_nxt = S_I3;
      end
      S_I3: begin
        ram_we     = 1'b1; ram_addr = AW'(12); ram_wd = TW'(1);
        gbytes_nxt = CHUNK_A;
        ret_nxt    = RET_INIT;
        state_nxt  = S_G0;
      end

      // grow the break
      S_G0: begin
        if (brk_r > HEAP_A || gsz > HEAP_A - brk_r) begin
          st_nxt    = ST_NO_HEAP;
          res_nxt   = '0;
          state_nxt = S_DONE;
          if (ret_r == RET_INIT) begin
            brk_nxt   = '0;
            rover_nxt = '0;
          end
        end else begin
          bp_nxt    = brk_r;
          brk_nxt   = brk_r + gsz;
          s_nxt     = gsz;
          state_nxt = S_G1;
        end
      end
      S_G1: begin
        ram_we = 1'b1; ram_addr = bp_r - AW'(4); ram_wd = TW'(s_r); state_nxt = S_G2;
      end
      S_G2: begin
        ram_we = 1'b1; ram_addr = bp_r + s_r - AW'(8); ram_wd = TW'(s_r); state_nxt = S_G3;
      end
      S_G3: begin
        ram_we = 1'b1; ram_addr = bp_r + s_r - AW'(4); ram_wd = TW'(1); state_nxt = S_M0;
      end

      // coalesce bp_r with free neighbors
      S_M0: begin
        ram_re = 1'b1; ram_addr = bp_r - AW'(8); state_nxt = S_M1;
      end
      S_M1: begin
        prev_nxt  = bp_r - szd;
        ram_re    = 1'b1; ram_addr = bp_r - szd - AW'(4);
        state_nxt = S_M2;
      end
      S_M2: begin
        phsz_nxt  = szd;
        ram_re    = 1'b1; ram_addr = prev_r + szd - AW'(8);
        state_nxt = S_M3;
      end
      S_M3: begin
        pa_nxt    = ald;
        ram_re    = 1'b1; ram_addr = bp_r - AW'(4);
        state_nxt = S_M4;
      end
      S_M4: begin
        s_nxt     = szd;
        next_nxt  = bp_r + szd;
        ram_re    = 1'b1; ram_addr = bp_r + szd - AW'(4);
        state_nxt = S_M5;
      end
      S_M5: begin
        nsz_nxt = szd;
        if (pa_r && ald) begin
          merge_done = 1'b1;
        end else if (pa_r) begin
          s_nxt     = s_r + szd;
          state_nxt = S_MA1;
        end else if (ald) begin
          s_nxt     = s_r + phsz_r;
          state_nxt = S_MB1;
        end else begin
          s_nxt     = s_r + phsz_r;
          ram_re    = 1'b1; ram_addr = next_r + szd - AW'(8);
          state_nxt = S_M6;
        end
      end
      S_M6: begin
        s_nxt = s_r + szd; state_nxt = S_MC1;
      end
      S_MA1: begin
        ram_we = 1'b1; ram_addr = bp_r - AW'(4); ram_wd = TW'(s_r); state_nxt = S_MA2;
      end
      S_MA2: begin
        ram_we = 1'b1; ram_addr = bp_r + s_r - AW'(8); ram_wd = TW'(s_r); state_nxt = S_MR;
      end
      S_MB1: begin
        ram_we = 1'b1; ram_addr = next_r - AW'(8); ram_wd = TW'(s_r); state_nxt = S_MB2;
      end
      S_MB2: begin
        ram_we    = 1'b1; ram_addr = prev_r - AW'(4); ram_wd = TW'(s_r);
        bp_nxt    = prev_r;
        state_nxt = S_MR;
      end
      S_MC1: begin
        ram_we = 1'b1; ram_addr = prev_r - AW'(4); ram_wd = TW'(s_r); state_nxt = S_MC2;
      end
      S_MC2: begin
        ram_we    = 1'b1; ram_addr = next_r + nsz_r - AW'(8); ram_wd = TW'(s_r);
        bp_nxt    = prev_r;
        state_nxt = S_MR;
      end
      S_MR: begin
        // rover inside the merged block moves to its start
        if (rover_r >= bp_r && rover_r < bp_r + s_r) begin
          rover_nxt = bp_r;
        end
        merge_done = 1'b1;
      end

      // next-fit: rover up to the epilogue
      S_L1_RD: begin
        if (cnt_r >= CW'(LIMIT)) begin
          p_nxt     = AW'(8);
          cnt_nxt   = '0;
          state_nxt = S_L2_RD;
        end else begin
          ram_re    = 1'b1; ram_addr = p_r - AW'(4);
          state_nxt = S_L1_CK;
        end
      end
      S_L1_CK: begin
        if (szd == '0) begin
          p_nxt     = AW'(8);
          cnt_nxt   = '0;
          state_nxt = S_L2_RD;
        end else if (!ald && asize_r <= szd) begin
          rover_nxt = p_r;
          bp_nxt    = p_r;
          state_nxt = S_C0;
        end else begin
          p_nxt     = p_r + szd;
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = S_L1_RD;
        end
      end
      // then from the first block back up to where the search started
      S_L2_RD: begin
        if (cnt_r < CW'(LIMIT) && p_r < start_r) begin
          ram_re    = 1'b1; ram_addr = p_r - AW'(4);
          state_nxt = S_L2_CK;
        end else begin
          rover_nxt  = p_r;
          gbytes_nxt = (asize_r > CHUNK_A) ? asize_r : CHUNK_A;
          ret_nxt    = RET_ALLOC;
          state_nxt  = S_G0;
        end
      end
      S_L2_CK: begin
        if (!ald && asize_r <= szd) begin
          rover_nxt = p_r;
          bp_nxt    = p_r;
          state_nxt = S_C0;
        end else begin
          p_nxt     = p_r + szd;
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = S_L2_RD;
        end
      end

      // place the request, split when the remainder is a legal block
      S_C0: begin
        ram_re = 1'b1; ram_addr = bp_r - AW'(4); state_nxt = S_C1;
      end
      S_C1: begin
        s_nxt     = szd;
        state_nxt = (szd - asize_r >= AW'(16)) ? S_C2 : S_C6;
      end
      S_C2: begin
        ram_we = 1'b1; ram_addr = bp_r - AW'(4); ram_wd = TW'(asize_r | AW'(1));
        state_nxt = S_C3;
      end
      S_C3: begin
        ram_we = 1'b1; ram_addr = bp_r + asize_r - AW'(8); ram_wd = TW'(asize_r | AW'(1));
        state_nxt = S_C4;
      end
      S_C4: begin
        ram_we = 1'b1; ram_addr = bp_r + asize_r - AW'(4); ram_wd = TW'(csz_diff);
        state_nxt = S_C5;
      end
      S_C5: begin
        ram_we    = 1'b1; ram_addr = bp_r + s_r - AW'(8); ram_wd = TW'(csz_diff);
        res_nxt   = bp_r; st_nxt = ST_OK;
        state_nxt = S_DONE;
      end
      S_C6: begin
        ram_we = 1'b1; ram_addr = bp_r - AW'(4); ram_wd = TW'(s_r | AW'(1));
        state_nxt = S_C7;
      end
      S_C7: begin
        ram_we    = 1'b1; ram_addr = bp_r + s_r - AW'(8); ram_wd = TW'(s_r | AW'(1));
        res_nxt   = bp_r; st_nxt = ST_OK;
        state_nxt = S_DONE;
      end

      // free: check header and footer, clear, then coalesce
      S_F0: begin
        ram_re = 1'b1; ram_addr = bp_r - AW'(4); state_nxt = S_F1;
      end
      S_F1: begin
        h_nxt = rd_data;
        s_nxt = szd;
        if (ald && szd != '0 && szd <= brk_r - bp_r && bp_r + szd - AW'(4) <= brk_r) begin
          ram_re    = 1'b1; ram_addr = bp_r + szd - AW'(8);
          state_nxt = S_F2;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_F2: begin
        state_nxt = (rd_data == h_r) ? S_F3 : S_DONE;
      end
      S_F3: begin
        ram_we = 1'b1; ram_addr = bp_r - AW'(4); ram_wd = TW'(s_r); state_nxt = S_F4;
      end
      S_F4: begin
        ram_we    = 1'b1; ram_addr = bp_r + s_r - AW'(8); ram_wd = TW'(s_r);
        ret_nxt   = RET_FREE;
        state_nxt = S_M0;
      end

      S_DONE: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // return from coalescing to the command that asked for it
    if (merge_done) begin
      case (ret_r)
        RET_INIT: begin
          rover_nxt = AW'(8);
          init_nxt  = 1'b1;
          res_nxt   = '0;
          st_nxt    = ST_OK;
          state_nxt = S_DONE;
        end
        RET_ALLOC: state_nxt = S_C0;
        default: begin
          res_nxt   = '0;
          st_nxt    = ST_OK;
          state_nxt = S_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      init_r  <= 1'b0;
      brk_r   <= '0;
      rover_r <= '0;
      ret_r   <= RET_INIT;
    end else begin
      state_r <= state_nxt;
      init_r  <= init_nxt;
      brk_r   <= brk_nxt;
      rover_r <= rover_nxt;
      ret_r   <= ret_nxt;
    end
    bp_r     <= bp_nxt;
    asize_r  <= asize_nxt;
    s_r      <= s_nxt;
    prev_r   <= prev_nxt;
    phsz_r   <= phsz_nxt;
    next_r   <= next_nxt;
    nsz_r    <= nsz_nxt;
    pa_r     <= pa_nxt;
    start_r  <= start_nxt;
    p_r      <= p_nxt;
    cnt_r    <= cnt_nxt;
    gbytes_r <= gbytes_nxt;
    h_r      <= h_nxt;
    res_r    <= res_nxt;
    st_r     <= st_nxt;
  end

  btnf_out_reg u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (out_push),
    .item              (out_item),
    .ready             (out_ready),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_payload_offset(out_payload_offset),
    .out_status        (out_status)
  );

  `BTNF_CHECK(a_ram_one_op, !(ram_re && ram_we), "tag RAM read and write in one cycle")
  `BTNF_CHECK(a_brk_bound, brk_r <= HEAP_A, "break beyond heap")
  `BTNF_CHECK(a_init_brk, !init_r || brk_r >= AW'(16), "initialized heap without prologue")
  `BTNF_CHECK_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall, "second transfer taken")
  `BTNF_CHECK_NEXT(a_push_shows, out_push, out_valid, "result lost at output register")
endmodule
`default_nettype wire

// ----- hdl/btnf_tag_ram.sv -----
// Tag word memory: one write and one registered read per cycle, zero outside the heap.
`default_nettype none
module btnf_tag_ram #(
  parameter int HEAP_BYTES = 65536,
  parameter int ADDR_W     = 18,
  parameter int TAG_W      = 16
) (
  input  wire logic              clk,
  input  wire logic              rd_en,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic [TAG_W-1:0]  wdata,
  output logic      [TAG_W-1:0]  rdata
);
  localparam int WORDS = HEAP_BYTES / 4;
  localparam int IW    = $clog2(WORDS);

  logic [TAG_W-1:0] mem [WORDS];
  logic [TAG_W-1:0] q_r;
  logic             oob_r;
  logic             in_heap;

  assign in_heap = addr < ADDR_W'(HEAP_BYTES);

  always_ff @(posedge clk) begin
    if (wr_en && in_heap) begin
      mem[addr[IW+1:2]] <= wdata;
    end
    if (rd_en) begin
      q_r   <= mem[addr[IW+1:2]];
      oob_r <= !in_heap;
    end
  end

  // tags outside the heap read as zero
  assign rdata = oob_r ? '0 : q_r;
endmodule
`default_nettype wire

// ----- hdl/btnf_out_reg.sv -----
// Result output register: holds one item until the receiver takes it.
`default_nettype none
module btnf_out_reg (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire btnf_pkg::out_item_t item,
  output logic                     ready,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [15:0]              out_payload_offset,
  output btnf_pkg::status_t        out_status
);
  import btnf_pkg::*;

  logic      valid_r;
  out_item_t data_r;

  assign ready = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
    if (push) begin
      data_r <= item;
    end
  end

  assign out_valid          = valid_r;
  assign out_payload_offset = data_r.payload_offset;
  assign out_status         = data_r.status;
endmodule
`default_nettype wire
